// File: src/sof_timing_monitor_defines.svh
// Assertion macros shared by the SOF timing monitor modules.
// Depends on a clk and an active-low rst_n in the module that uses them.
`ifndef SOF_TIMING_MONITOR_DEFINES_SVH
`define SOF_TIMING_MONITOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SOFM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SOFM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sofm_pkg.sv
// Shared types, defaults and word codes for the SOF timing monitor.
// No dependencies.
package sofm_pkg;

    localparam int DELTA_BUCKETS_DEF = 8;
    localparam int ANOMALY_SLOTS_DEF = 4;
    localparam int FRAME_BITS_DEF    = 14;

    localparam int FRAME_IN_W  = 14;   // width of the frame index input fields
    localparam int FRAME_EXT_W = 16;   // widest frame mask supported
    localparam int TICK_W      = 32;
    localparam int CNT32_W     = 32;
    localparam int WORD_W      = 64;
    localparam int ANOM_WORDS  = 7;
    localparam int ANOM_SEL_W  = 3;
    localparam int STAT_TAIL   = 11;   // snapshot words besides the histogram
    localparam int REL_W       = 4;

    localparam logic [CNT32_W-1:0] GAP_MIN_INIT = 32'hFFFF_FFFF;

    // Snapshot words that follow the histogram, relative to its end.
    localparam logic [REL_W-1:0] SR_RACE       = 4'd0;
    localparam logic [REL_W-1:0] SR_ANOM_CNT   = 4'd1;
    localparam logic [REL_W-1:0] SR_LAST_FRAME = 4'd2;
    localparam logic [REL_W-1:0] SR_LAST_TIME  = 4'd3;
    localparam logic [REL_W-1:0] SR_MF_TOTAL   = 4'd4;
    localparam logic [REL_W-1:0] SR_GAP_MIN    = 4'd5;
    localparam logic [REL_W-1:0] SR_GAP_MAX    = 4'd6;
    localparam logic [REL_W-1:0] SR_GAP_SUM    = 4'd7;
    localparam logic [REL_W-1:0] SR_GAP_COUNT  = 4'd8;
    localparam logic [REL_W-1:0] SR_FILL       = 4'd9;

    // Words of one stored anomaly, in emit order.
    localparam logic [ANOM_SEL_W-1:0] AW_PREV     = 3'd0;
    localparam logic [ANOM_SEL_W-1:0] AW_CUR      = 3'd1;
    localparam logic [ANOM_SEL_W-1:0] AW_DELTA    = 3'd2;
    localparam logic [ANOM_SEL_W-1:0] AW_INTERVAL = 3'd3;
    localparam logic [ANOM_SEL_W-1:0] AW_STATUS   = 3'd4;
    localparam logic [ANOM_SEL_W-1:0] AW_PORT     = 3'd5;
    localparam logic [ANOM_SEL_W-1:0] AW_NOW      = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_STATS,
        ST_ANOM
    } sofm_state_t;

    typedef struct packed {
        logic capture;   // latch an SOF transaction, form delta and interval
        logic update;    // fold the latched event into the statistics
        logic load;      // load the output register
        logic anom_sel;  // loaded word comes from the anomaly store
        logic last;      // loaded word ends the snapshot run
        logic clear;     // clear the period statistics
    } sofm_cmd_t;

    typedef struct packed {
        logic load_ok;   // output register can take a word this cycle
        logic fill_zero; // anomaly store is empty
    } sofm_status_t;

endpackage

// File: src/sofm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sofm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/sofm_ctrl.sv
// Controller of the SOF timing monitor: input handshake and snapshot sequencer.
// Depends on sofm_pkg and sof_timing_monitor_defines.svh.
`include "sof_timing_monitor_defines.svh"

module sofm_ctrl
    import sofm_pkg::*;
#(
    parameter int DELTA_BUCKETS = DELTA_BUCKETS_DEF,
    parameter int ANOMALY_SLOTS = ANOMALY_SLOTS_DEF,
    localparam int STAT_WORDS   = DELTA_BUCKETS + STAT_TAIL,
    localparam int IDX_W        = $clog2(STAT_WORDS),
    localparam int SLOT_W       = ANOMALY_SLOTS > 1 ? $clog2(ANOMALY_SLOTS) : 1,
    localparam int FILL_W       = $clog2(ANOMALY_SLOTS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  action,
    output logic                  in_stall,
    input  sofm_status_t          status,
    input  logic [FILL_W-1:0]     fill,
    output sofm_cmd_t             cmd,
    output logic [IDX_W-1:0]      stat_idx,
    output logic [SLOT_W-1:0]     slot,
    output logic [SLOT_W-1:0]     rd_slot,
    output logic [ANOM_SEL_W-1:0] anom_word
);

    localparam int CNT_W = SLOT_W + 1;
    localparam logic [IDX_W-1:0] STAT_LAST = IDX_W'(STAT_WORDS - 1);

    sofm_state_t           state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [ANOM_SEL_W-1:0] aw_reg, aw_next;

    logic stat_done;
    logic anom_row_done;
    logic slot_final;

    assign stat_done     = (idx_reg == STAT_LAST);
    assign anom_row_done = (aw_reg == AW_NOW);
    assign slot_final    = ((CNT_W'(slot_reg) + CNT_W'(1)) == CNT_W'(fill));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            slot_reg  <= '0;
            aw_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            slot_reg  <= slot_next;
            aw_reg    <= aw_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = action ? ST_STATS : ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            ST_STATS:
            begin
                if (status.load_ok && stat_done)
                begin
                    state_next = status.fill_zero ? ST_IDLE : ST_ANOM;
                end
            end
            ST_ANOM:
            begin
                if (status.load_ok && anom_row_done && slot_final)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and counters
    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        idx_next  = idx_reg;
        slot_next = slot_reg;
        aw_next   = aw_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                idx_next  = '0;
                slot_next = '0;
                aw_next   = '0;
                if (in_valid && !action)
                begin
                    cmd.capture = 1'b1;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_STATS:
            begin
                if (status.load_ok)
                begin
                    cmd.load = 1'b1;
                    if (stat_done)
                    begin
                        cmd.last  = status.fill_zero;
                        cmd.clear = status.fill_zero;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_ANOM:
            begin
                cmd.anom_sel = 1'b1;
                if (status.load_ok)
                begin
                    cmd.load = 1'b1;
                    if (anom_row_done)
                    begin
                        aw_next = '0;
                        if (slot_final)
                        begin
                            cmd.last  = 1'b1;
                            cmd.clear = 1'b1;
                        end
                        else
                        begin
                            slot_next = slot_reg + SLOT_W'(1);
                        end
                    end
                    else
                    begin
                        aw_next = aw_reg + ANOM_SEL_W'(1);
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign stat_idx  = idx_reg;
    assign slot      = slot_reg;
    assign rd_slot   = slot_next;
    assign anom_word = aw_reg;

    `SOFM_ASSERT_NEXT(a_update_one_cycle, state_reg == ST_UPDATE, state_reg == ST_IDLE,
        "update state lasted more than one cycle")
    `SOFM_ASSERT_NOW(a_slot_in_fill, state_reg == ST_ANOM,
        CNT_W'(slot_reg) < CNT_W'(fill), "anomaly readout beyond fill level")
    `SOFM_ASSERT_NOW(a_load_needs_room, cmd.load, status.load_ok,
        "output register loaded while full and stalled")
    `SOFM_ASSERT_NOW(a_word_range, state_reg == ST_ANOM, aw_reg <= AW_NOW,
        "anomaly word counter out of range")

endmodule

// File: src/sofm_datapath.sv
// Datapath of the SOF timing monitor: statistics, anomaly store, output register.
// Depends on sofm_pkg, sofm_ram and sof_timing_monitor_defines.svh.
`include "sof_timing_monitor_defines.svh"

module sofm_datapath
    import sofm_pkg::*;
#(
    parameter int DELTA_BUCKETS = DELTA_BUCKETS_DEF,
    parameter int ANOMALY_SLOTS = ANOMALY_SLOTS_DEF,
    parameter int FRAME_BITS    = FRAME_BITS_DEF,
    localparam int STAT_WORDS   = DELTA_BUCKETS + STAT_TAIL,
    localparam int IDX_W        = $clog2(STAT_WORDS),
    localparam int SLOT_W       = ANOMALY_SLOTS > 1 ? $clog2(ANOMALY_SLOTS) : 1,
    localparam int FILL_W       = $clog2(ANOMALY_SLOTS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [FRAME_IN_W-1:0] frame_entry,
    input  logic [FRAME_IN_W-1:0] frame_recheck,
    input  logic [TICK_W-1:0]     now_ticks,
    input  logic [CNT32_W-1:0]    status_word,
    input  logic [CNT32_W-1:0]    port_word,
    input  sofm_cmd_t             cmd,
    input  logic [IDX_W-1:0]      stat_idx,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [SLOT_W-1:0]     rd_slot,
    input  logic [ANOM_SEL_W-1:0] anom_word,
    output sofm_status_t          status,
    output logic [FILL_W-1:0]     fill,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [WORD_W-1:0]     word,
    output logic                  last
);

    localparam int HB_W  = $clog2(DELTA_BUCKETS);
    localparam int FB    = FRAME_BITS;
    // Anomaly row layout, LSB first: now, port, status, interval, delta, cur, prev
    localparam int O_PORT   = TICK_W;
    localparam int O_STATUS = O_PORT + CNT32_W;
    localparam int O_INTVL  = O_STATUS + CNT32_W;
    localparam int O_DELTA  = O_INTVL + TICK_W;
    localparam int O_CUR    = O_DELTA + FB;
    localparam int O_PREV   = O_CUR + FRAME_IN_W;
    localparam int ROW_W    = O_PREV + FB;
    localparam logic [HB_W-1:0] TOP_BUCKET = HB_W'(DELTA_BUCKETS - 1);

    logic [CNT32_W-1:0]    sof_total_reg;
    logic [CNT32_W-1:0]    race_total_reg;
    logic [CNT32_W-1:0]    anomaly_count_reg;
    logic [CNT32_W-1:0]    hist_reg [DELTA_BUCKETS];
    logic [FRAME_IN_W-1:0] last_frame_reg;
    logic [TICK_W-1:0]     last_time_reg;
    logic [FRAME_IN_W-1:0] prev_frame_reg;
    logic [TICK_W-1:0]     prev_time_reg;
    logic                  prev_valid_reg;
    logic [WORD_W-1:0]     mf_total_reg;
    logic [CNT32_W-1:0]    gap_min_reg;
    logic [CNT32_W-1:0]    gap_max_reg;
    logic [WORD_W-1:0]     gap_sum_reg;
    logic [CNT32_W-1:0]    gap_count_reg;
    logic [FILL_W-1:0]     fill_reg;

    // Latched SOF event between capture and update
    logic                  have_gap_reg;
    logic [FB-1:0]         delta_reg;
    logic [TICK_W-1:0]     interval_reg;
    logic [FB-1:0]         ev_prev_reg;
    logic [FRAME_IN_W-1:0] ev_cur_reg;
    logic [CNT32_W-1:0]    ev_status_reg;
    logic [CNT32_W-1:0]    ev_port_reg;
    logic [TICK_W-1:0]     ev_now_reg;

    logic                  out_valid_reg;
    logic [WORD_W-1:0]     word_reg;
    logic                  last_reg;

    logic [FRAME_EXT_W-1:0] delta_wide;
    logic [FRAME_EXT_W-1:0] prev_ext;
    logic [HB_W-1:0]        bucket;
    logic                   fold;
    logic                   is_anomaly;
    logic                   store_we;
    logic [ROW_W-1:0]       wr_row;
    logic [ROW_W-1:0]       rd_row;
    logic [WORD_W-1:0]      stat_word;
    logic [WORD_W-1:0]      anom_val;
    logic [WORD_W-1:0]      next_word;
    logic [HB_W-1:0]        hist_idx;
    logic [REL_W-1:0]       rel_idx;
    logic                   load_ok;

    assign prev_ext   = FRAME_EXT_W'(prev_frame_reg);
    assign delta_wide = FRAME_EXT_W'(frame_entry) - prev_ext;

    assign bucket = (FRAME_EXT_W'(delta_reg) < FRAME_EXT_W'(DELTA_BUCKETS - 1))
                  ? HB_W'(delta_reg) : TOP_BUCKET;
    assign fold       = cmd.update && have_gap_reg;
    assign is_anomaly = (delta_reg != FB'(1));
    assign store_we   = fold && is_anomaly && (fill_reg < FILL_W'(ANOMALY_SLOTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_total_reg     <= '0;
            race_total_reg    <= '0;
            anomaly_count_reg <= '0;
            last_frame_reg    <= '0;
            last_time_reg     <= '0;
            prev_frame_reg    <= '0;
            prev_time_reg     <= '0;
            prev_valid_reg    <= 1'b0;
            mf_total_reg      <= '0;
            gap_min_reg       <= GAP_MIN_INIT;
            gap_max_reg       <= '0;
            gap_sum_reg       <= '0;
            gap_count_reg     <= '0;
            fill_reg          <= '0;
            have_gap_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                sof_total_reg  <= sof_total_reg + CNT32_W'(1);
                last_frame_reg <= frame_entry;
                last_time_reg  <= now_ticks;
                if (frame_recheck != frame_entry)
                begin
                    race_total_reg <= race_total_reg + CNT32_W'(1);
                end
                prev_valid_reg <= 1'b1;
                prev_frame_reg <= frame_entry;
                prev_time_reg  <= now_ticks;
                have_gap_reg   <= prev_valid_reg;
            end
            if (fold)
            begin
                mf_total_reg <= mf_total_reg + WORD_W'(delta_reg);
                if (interval_reg < gap_min_reg)
                begin
                    gap_min_reg <= interval_reg;
                end
                if (interval_reg > gap_max_reg)
                begin
                    gap_max_reg <= interval_reg;
                end
                gap_sum_reg   <= gap_sum_reg + WORD_W'(interval_reg);
                gap_count_reg <= gap_count_reg + CNT32_W'(1);
                if (is_anomaly)
                begin
                    anomaly_count_reg <= anomaly_count_reg + CNT32_W'(1);
                end
                if (store_we)
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
            if (cmd.clear)
            begin
                gap_min_reg   <= GAP_MIN_INIT;
                gap_max_reg   <= '0;
                gap_sum_reg   <= '0;
                gap_count_reg <= '0;
                fill_reg      <= '0;
            end
        end
    end

    // Event details held for the update cycle
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            delta_reg     <= delta_wide[FB-1:0];
            interval_reg  <= now_ticks - prev_time_reg;
            ev_prev_reg   <= prev_ext[FB-1:0];
            ev_cur_reg    <= frame_entry;
            ev_status_reg <= status_word;
            ev_port_reg   <= port_word;
            ev_now_reg    <= now_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DELTA_BUCKETS; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < DELTA_BUCKETS; k++)
            begin
                if (fold && (bucket == HB_W'(k)))
                begin
                    hist_reg[k] <= hist_reg[k] + CNT32_W'(1);
                end
            end
        end
    end

    assign wr_row = {ev_prev_reg, ev_cur_reg, delta_reg, interval_reg,
                     ev_status_reg, ev_port_reg, ev_now_reg};

    sofm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ANOMALY_SLOTS)
    ) u_store (
        .clk     (clk),
        .we      (store_we),
        .wr_addr (SLOT_W'(fill_reg)),
        .wr_data (wr_row),
        .rd_addr (rd_slot),
        .rd_data (rd_row)
    );

    assign hist_idx = HB_W'(stat_idx - IDX_W'(1));
    assign rel_idx  = REL_W'(stat_idx - IDX_W'(DELTA_BUCKETS + 1));

    always_comb
    begin
        stat_word = '0;
        if (stat_idx == '0)
        begin
            stat_word = WORD_W'(sof_total_reg);
        end
        else if (stat_idx <= IDX_W'(DELTA_BUCKETS))
        begin
            stat_word = WORD_W'(hist_reg[hist_idx]);
        end
        else
        begin
            unique case (rel_idx)
                SR_RACE:       stat_word = WORD_W'(race_total_reg);
                SR_ANOM_CNT:   stat_word = WORD_W'(anomaly_count_reg);
                SR_LAST_FRAME: stat_word = WORD_W'(last_frame_reg);
                SR_LAST_TIME:  stat_word = WORD_W'(last_time_reg);
                SR_MF_TOTAL:   stat_word = mf_total_reg;
                SR_GAP_MIN:    stat_word = (gap_count_reg == '0) ? '0 : WORD_W'(gap_min_reg);
                SR_GAP_MAX:    stat_word = WORD_W'(gap_max_reg);
                SR_GAP_SUM:    stat_word = gap_sum_reg;
                SR_GAP_COUNT:  stat_word = WORD_W'(gap_count_reg);
                SR_FILL:       stat_word = WORD_W'(fill_reg);
                default:       stat_word = '0;
            endcase
        end
    end

    always_comb
    begin
        unique case (anom_word)
            AW_PREV:     anom_val = WORD_W'(rd_row[O_PREV +: FB]);
            AW_CUR:      anom_val = WORD_W'(rd_row[O_CUR +: FRAME_IN_W]);
            AW_DELTA:    anom_val = WORD_W'(rd_row[O_DELTA +: FB]);
            AW_INTERVAL: anom_val = WORD_W'(rd_row[O_INTVL +: TICK_W]);
            AW_STATUS:   anom_val = WORD_W'(rd_row[O_STATUS +: CNT32_W]);
            AW_PORT:     anom_val = WORD_W'(rd_row[O_PORT +: CNT32_W]);
            AW_NOW:      anom_val = WORD_W'(rd_row[0 +: TICK_W]);
            default:     anom_val = '0;
        endcase
    end

    assign next_word = cmd.anom_sel ? anom_val : stat_word;
    assign load_ok   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
            last_reg      <= cmd.last;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= next_word;
        end
    end

    assign status.load_ok   = load_ok;
    assign status.fill_zero = (fill_reg == '0);
    assign fill      = fill_reg;
    assign out_valid = out_valid_reg;
    assign word      = word_reg;
    assign last      = last_reg;

    `SOFM_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(ANOMALY_SLOTS),
        "anomaly fill level above slot count")
    `SOFM_ASSERT_NEXT(a_fill_hold, !cmd.update && !cmd.clear, $stable(fill_reg),
        "anomaly fill changed without update or clear")
    `SOFM_ASSERT_NEXT(a_last_loaded, cmd.load && cmd.last, out_valid_reg && last_reg,
        "final snapshot word not presented")
    `SOFM_ASSERT_NOW(a_slot_readout, cmd.anom_sel && cmd.load,
        (SLOT_W + 1)'(slot) < (SLOT_W + 1)'(fill_reg), "readout of an unfilled slot")

endmodule

// File: src/sof_timing_monitor.sv
// Top level of the SOF timing monitor: controller plus datapath.
// Depends on sofm_pkg, sofm_ctrl and sofm_datapath.
//
//  Chan Handshake          Payload
//  in   in_valid/in_stall  action, frame_entry, frame_recheck, now_ticks, status_word, port_word
//  out  out_valid/out_stall  word, last
//
// An SOF event is captured with delta and interval in the idle state, then the
// statistics update follows in the update state. A snapshot is accepted in the
// idle state, then DELTA_BUCKETS + 11 statistics words and 7 words per stored anomaly
// go out one word a cycle through the single output register, unless out_stall holds
// it. A new transaction is taken while the last snapshot word still waits.
// Reset is asynchronous and needs no clearing pass; the anomaly store is read
// only below its fill level.
module sof_timing_monitor
    import sofm_pkg::*;
#(
    parameter int DELTA_BUCKETS = DELTA_BUCKETS_DEF,
    parameter int ANOMALY_SLOTS = ANOMALY_SLOTS_DEF,
    parameter int FRAME_BITS    = FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [FRAME_IN_W-1:0] frame_entry,
    input  logic [FRAME_IN_W-1:0] frame_recheck,
    input  logic [TICK_W-1:0]     now_ticks,
    input  logic [CNT32_W-1:0]    status_word,
    input  logic [CNT32_W-1:0]    port_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [WORD_W-1:0]     word,
    output logic                  last
);

    localparam int STAT_WORDS = DELTA_BUCKETS + STAT_TAIL;
    localparam int IDX_W      = $clog2(STAT_WORDS);
    localparam int SLOT_W     = ANOMALY_SLOTS > 1 ? $clog2(ANOMALY_SLOTS) : 1;
    localparam int FILL_W     = $clog2(ANOMALY_SLOTS + 1);

    sofm_cmd_t             cmd;
    sofm_status_t          status;
    logic [FILL_W-1:0]     fill;
    logic [IDX_W-1:0]      stat_idx;
    logic [SLOT_W-1:0]     slot;
    logic [SLOT_W-1:0]     rd_slot;
    logic [ANOM_SEL_W-1:0] anom_word;

    sofm_ctrl #(
        .DELTA_BUCKETS (DELTA_BUCKETS),
        .ANOMALY_SLOTS (ANOMALY_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .in_stall  (in_stall),
        .status    (status),
        .fill      (fill),
        .cmd       (cmd),
        .stat_idx  (stat_idx),
        .slot      (slot),
        .rd_slot   (rd_slot),
        .anom_word (anom_word)
    );

    sofm_datapath #(
        .DELTA_BUCKETS (DELTA_BUCKETS),
        .ANOMALY_SLOTS (ANOMALY_SLOTS),
        .FRAME_BITS    (FRAME_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_entry   (frame_entry),
        .frame_recheck (frame_recheck),
        .now_ticks     (now_ticks),
        .status_word   (status_word),
        .port_word     (port_word),
        .cmd           (cmd),
        .stat_idx      (stat_idx),
        .slot          (slot),
        .rd_slot       (rd_slot),
        .anom_word     (anom_word),
        .status        (status),
        .fill          (fill),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .word          (word),
        .last          (last)
    );

endmodule
